@@ hw/rtl/arpc_pkg.sv @@
// Package for the ARP responder with neighbor cache.
// Shared types, codes and constants; no dependencies.
`timescale 1ns / 1ps
package arpc_pkg;

  localparam logic [1:0] REQ_FRAME  = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_SEND   = 2'd2;

  localparam logic [3:0] K_MISS       = 4'd0;
  localparam logic [3:0] K_HIT        = 4'd1;
  localparam logic [3:0] K_SEND_REQ   = 4'd2;
  localparam logic [3:0] K_SEND_REPLY = 4'd3;
  localparam logic [3:0] K_LEARNED    = 4'd4;
  localparam logic [3:0] K_SHORT      = 4'd5;
  localparam logic [3:0] K_BAD        = 4'd6;
  localparam logic [3:0] K_IGNORED    = 4'd7;
  localparam logic [3:0] K_NODEV      = 4'd8;

  localparam logic [15:0] HTYPE_ETHER     = 16'h0001;
  localparam logic [15:0] ETH_P_IP        = 16'h0800;
  localparam logic [15:0] OPER_REQUEST    = 16'd1;
  localparam logic [15:0] OPER_REPLY      = 16'd2;
  localparam logic [10:0] MIN_ARP_LEN     = 11'd28;
  localparam logic [47:0] MAC_BCAST       = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] ADDR_OWN_MAC = 2'd0;
  localparam logic [1:0] ADDR_OWN_IP  = 2'd1;
  localparam logic [1:0] ADDR_DEV     = 2'd2;

  // work the back end must do for a queued item
  typedef enum logic [1:0] {
    OP_DONE,    // result fully decided by the front end
    OP_LEARN,   // learn sender, then learned result
    OP_LEARN_Q, // learn sender, then reply if for us
    OP_LOOKUP
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  kind;
    logic        for_us;
    logic [47:0] mac;
    logic [31:0] sip;
    logic [31:0] tip;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_WRITE,
    B_OUT
  } bstate_t;

endpackage

@@ hw/rtl/arpc_front.sv @@
// Front end: accepts items and classifies them into back-end commands.
// Uses arpc_pkg; feeds arpc_queue.
`timescale 1ns / 1ps
module arpc_front
  import arpc_pkg::*;
(
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [10:0] payload_len,
  input  logic [15:0] hw_type,
  input  logic [15:0] proto_type,
  input  logic [7:0]  hw_len,
  input  logic [7:0]  proto_len,
  input  logic [15:0] opcode,
  input  logic [47:0] sender_mac,
  input  logic [31:0] sender_ip,
  input  logic [31:0] query_ip,
  input  logic [31:0] own_ip,
  input  logic        device_present,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  cmd_t c;

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign cmd       = c;

  always_comb begin
    c = '0;
    c.op   = OP_DONE;
    c.mac  = sender_mac;
    c.sip  = sender_ip;
    c.tip  = query_ip;
    c.for_us = (query_ip == own_ip) && (own_ip[31:24] != 8'd0);
    unique case (req_type)
      REQ_FRAME: begin
        if (payload_len < MIN_ARP_LEN) c.kind = K_SHORT;
        else if (hw_type != HTYPE_ETHER || proto_type != ETH_P_IP ||
                 hw_len != 8'd6 || proto_len != 8'd4) c.kind = K_BAD;
        else if (!device_present) c.kind = K_NODEV;
        else if (opcode == OPER_REPLY) begin
          c.op = OP_LEARN; c.kind = K_LEARNED;
        end else if (opcode == OPER_REQUEST) begin
          c.op = OP_LEARN_Q; c.kind = K_LEARNED;
        end else c.kind = K_IGNORED;
      end
      REQ_LOOKUP: begin
        c.op = OP_LOOKUP; c.kind = K_MISS;
      end
      REQ_SEND: c.kind = device_present ? K_SEND_REQ : K_NODEV;
      default:  c.kind = K_IGNORED;
    endcase
  end

endmodule

@@ hw/rtl/arpc_queue.sv @@
// Two-entry command queue between front and back ends.
// Uses arpc_pkg.
`timescale 1ns / 1ps
module arpc_queue
  import arpc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_data
);

  cmd_t       mem [2];
  logic       wp, rp;
  logic [1:0] count;
  logic       push, pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rp];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_data;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ hw/rtl/arpc_back.sv @@
// Back end: scans the neighbor cache one entry a cycle, learns and forms results.
// Uses arpc_pkg; cache is a memory in this module with valid bits in flops.
`timescale 1ns / 1ps
module arpc_back
  import arpc_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  input  logic [47:0] own_mac,
  input  logic [31:0] own_ip,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  result_kind,
  output logic [47:0] dest_mac,
  output logic [1:0]  tx_opcode,
  output logic [47:0] tx_sender_mac,
  output logic [31:0] tx_sender_ip,
  output logic [47:0] tx_target_mac,
  output logic [31:0] tx_target_ip,
  output logic [47:0] found_mac
);

  localparam int IW = $clog2(ENTRIES);

  bstate_t state, state_next;
  cmd_t    cur;
  logic [31:0] e_ip  [ENTRIES];
  logic [47:0] e_mac [ENTRIES];
  logic [ENTRIES-1:0] e_valid;
  logic [IW:0]   idx;
  logic [IW-1:0] hit_idx, free_idx;
  logic          hit, free_seen;
  logic [31:0]   rd_ip;
  logic [47:0]   rd_mac;
  logic          rd_live;
  logic [IW-1:0] wr_idx;

  assign cmd_ready = (state == B_IDLE);
  assign out_valid = (state == B_OUT);
  assign wr_idx = hit ? hit_idx : (free_seen ? free_idx : '0);

  always_ff @(posedge clk) begin
    if (state == B_SCAN) begin
      rd_ip  <= e_ip[idx[IW-1:0]];
      rd_mac <= e_mac[idx[IW-1:0]];
    end
    if (state == B_WRITE && cur.op != OP_LOOKUP) begin
      e_mac[wr_idx] <= cur.mac;
      e_ip[wr_idx]  <= cur.sip;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (cmd_valid) state_next = (cmd.op == OP_DONE) ? B_OUT : B_SCAN;
      B_SCAN:  if (idx == IW'(0) + (IW+1)'(ENTRIES)) state_next = B_WRITE;
      B_WRITE: state_next = B_OUT;
      B_OUT:   if (out_ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // read data is registered, so it arrives in the cycle after the scan index that addressed it
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE; e_valid <= '0;
    end else begin
      state <= state_next;
      if (state == B_WRITE && cur.op != OP_LOOKUP) e_valid[wr_idx] <= 1'b1;
    end
    unique case (state)
      B_IDLE: begin
        cur <= cmd; idx <= '0; hit <= 1'b0; free_seen <= 1'b0;
        rd_live <= 1'b0; found_mac <= '0;
      end
      B_SCAN: begin
        rd_live <= e_valid[idx[IW-1:0]] && (idx != (IW+1)'(ENTRIES));
        if (idx != (IW+1)'(ENTRIES)) idx <= idx + 1'b1;
        if (idx != '0) begin
          if (!hit && rd_live && rd_ip == (cur.op == OP_LOOKUP ? cur.tip : cur.sip)) begin
            hit <= 1'b1; hit_idx <= IW'(idx - 1'b1); found_mac <= rd_mac;
          end
          if (!free_seen && !e_valid[IW'(idx - 1'b1)]) begin
            free_seen <= 1'b1; free_idx <= IW'(idx - 1'b1);
          end
        end
      end
      B_WRITE: begin
        if (cur.op == OP_LOOKUP) begin
          if (hit) cur.kind <= K_HIT; else found_mac <= '0;
        end else if (cur.op == OP_LEARN_Q && cur.for_us) cur.kind <= K_SEND_REPLY;
        if (cur.op != OP_LOOKUP) found_mac <= '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    result_kind = cur.kind;
    dest_mac = '0; tx_opcode = 2'd0; tx_sender_mac = '0; tx_sender_ip = '0;
    tx_target_mac = '0; tx_target_ip = '0;
    if (cur.kind == K_SEND_REPLY) begin
      dest_mac = cur.mac; tx_opcode = 2'd2; tx_sender_mac = own_mac;
      tx_sender_ip = own_ip; tx_target_mac = cur.mac; tx_target_ip = cur.sip;
    end else if (cur.kind == K_SEND_REQ) begin
      dest_mac = MAC_BCAST; tx_opcode = 2'd1; tx_sender_mac = own_mac;
      tx_sender_ip = own_ip; tx_target_ip = cur.tip;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_lookup_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != K_HIT |-> found_mac == '0) else $error("found_mac");
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    state != B_IDLE |-> !cmd_ready) else $error("busy accept");

endmodule

@@ hw/rtl/arp_responder_with_cache.sv @@
// ARP responder with neighbor cache: top level, register port and wiring.
// Uses arpc_pkg, arpc_front, arpc_queue, arpc_back.
`timescale 1ns / 1ps
// Each item goes through a two-entry queue to the back end, which scans the
// CACHE_ENTRIES-entry cache one entry per cycle through its memory read port
// for frames that learn and for lookups; items decided up front skip the scan.
// Valid bits clear at reset; no clearing pass.
// Registers: 0x00 own_mac, 0x08 own_ip, 0x10 device_present (64-bit data).
module arp_responder_with_cache
  import arpc_pkg::*;
#(
  parameter int CACHE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [10:0] payload_len,
  input  logic [15:0] hw_type,
  input  logic [15:0] proto_type,
  input  logic [7:0]  hw_len,
  input  logic [7:0]  proto_len,
  input  logic [15:0] opcode,
  input  logic [47:0] sender_mac,
  input  logic [31:0] sender_ip,
  input  logic [31:0] query_ip,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  result_kind,
  output logic [47:0] dest_mac,
  output logic [1:0]  tx_opcode,
  output logic [47:0] tx_sender_mac,
  output logic [31:0] tx_sender_ip,
  output logic [47:0] tx_target_mac,
  output logic [31:0] tx_target_ip,
  output logic [47:0] found_mac
);

  logic [47:0] own_mac;
  logic [31:0] own_ip;
  logic        device_present;
  logic        fq_valid, fq_ready, qb_valid, qb_ready;
  cmd_t        fq_cmd, qb_cmd;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac <= '0; own_ip <= '0; device_present <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
      unique case (reg_idx)
        ADDR_OWN_MAC: own_mac <= pwdata[47:0];
        ADDR_OWN_IP:  own_ip <= pwdata[31:0];
        ADDR_DEV:     device_present <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      ADDR_OWN_MAC: prdata = {16'd0, own_mac};
      ADDR_OWN_IP:  prdata = {32'd0, own_ip};
      ADDR_DEV:     prdata = {63'd0, device_present};
      default:      prdata = '0;
    endcase
  end

  arpc_front u_front (
    .in_valid, .in_ready, .req_type, .payload_len, .hw_type,
    .proto_type, .hw_len, .proto_len, .opcode, .sender_mac, .sender_ip,
    .query_ip, .own_ip, .device_present,
    .cmd_valid(fq_valid), .cmd_ready(fq_ready), .cmd(fq_cmd)
  );

  arpc_queue u_queue (
    .clk, .rst, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_cmd),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_cmd)
  );

  arpc_back #(.ENTRIES(CACHE_ENTRIES)) u_back (
    .clk, .rst, .cmd_valid(qb_valid), .cmd_ready(qb_ready), .cmd(qb_cmd),
    .own_mac, .own_ip, .out_valid, .out_ready, .result_kind, .dest_mac,
    .tx_opcode, .tx_sender_mac, .tx_sender_ip, .tx_target_mac, .tx_target_ip,
    .found_mac
  );

endmodule
